// ===== hw/rtl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants of the number property classifier
// Widths, divisor class codes, controller/datapath command and status words.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int VALUE_WIDTH   = 16;
  // Trial divisors never exceed the square root of the largest value plus one.
  localparam int DIV_WIDTH     = (VALUE_WIDTH + 1) / 2 + 1;
  // Step counter of the triangular search, one bit of headroom over a divisor.
  localparam int TRI_K_WIDTH   = DIV_WIDTH + 1;
  // The divisor sum of any value in range stays below eight times the value.
  localparam int SUM_WIDTH     = VALUE_WIDTH + 3;
  localparam int DIV_CNT_WIDTH = $clog2(VALUE_WIDTH);

  localparam logic [1:0] CLASS_DEFICIENT = 2'd0;
  localparam logic [1:0] CLASS_PERFECT   = 2'd1;
  localparam logic [1:0] CLASS_ABUNDANT  = 2'd2;
  localparam logic [1:0] CLASS_NONE      = 2'd3;

  typedef struct packed {
    logic load;       // capture a new input word
    logic tri_step;   // advance the triangular running sum
    logic div_start;  // start dividing the value by the current trial divisor
    logic acc;        // fold the divider result in and move to the next divisor
    logic publish;    // load the result registers
  } cmd_t;

  typedef struct packed {
    logic pos;        // captured value is above zero
    logic tri_done;   // triangular sum has reached or passed the value, or the value is not positive
    logic sq_over;    // square of the trial divisor exceeds the value
    logic div_busy;   // divider is still iterating
  } status_t;

  // Compares against every factorial that fits in the positive range.
  // The factorials themselves are constants and fold away at elaboration.
  function automatic logic is_factorial_fn(input logic [VALUE_WIDTH-1:0] v);
    logic [63:0] f;
    logic        hit;
    f   = 64'd1;
    hit = 1'b0;
    for (int k = 1; k <= 20; k++) begin
      f = f * 64'(k);
      if (f < (64'd1 << (VALUE_WIDTH - 1))) begin
        if (v == f[VALUE_WIDTH-1:0]) begin
          hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

endpackage

// ===== hw/rtl/npc_div.sv =====
// ----------------------------------------------------------------------------
// npc_div: restoring divider, one quotient bit per cycle
// Divides the value by a trial divisor and keeps quotient and remainder.
// ----------------------------------------------------------------------------
module npc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [npc_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [npc_pkg::DIV_WIDTH-1:0]   divisor,
  output logic                          busy,
  output logic [npc_pkg::VALUE_WIDTH-1:0] quotient,
  output logic [npc_pkg::DIV_WIDTH-1:0]   remainder
);
  import npc_pkg::*;

  logic                     busy_r, busy_nxt;
  logic [DIV_CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0]   quo_r, quo_nxt;
  logic [DIV_WIDTH-1:0]     rem_r, rem_nxt;
  logic [DIV_WIDTH-1:0]     dsr_r, dsr_nxt;
  logic [DIV_WIDTH:0]       trial;
  logic [DIV_WIDTH:0]       diff;
  logic                     fits;

  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], fits};
      rem_nxt = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_WIDTH'(VALUE_WIDTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hw/rtl/npc_dpath.sv =====
// ----------------------------------------------------------------------------
// npc_dpath: datapath of the number property classifier
// Holds the value, the triangular search, the trial divisor loop and results.
// ----------------------------------------------------------------------------
module npc_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  npc_pkg::cmd_t                   cmd,
  output npc_pkg::status_t                status,
  input  logic [npc_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                            out_is_natural,
  output logic                            out_is_even,
  output logic                            out_is_prime,
  output logic                            out_is_triangular,
  output logic                            out_is_square,
  output logic                            out_is_factorial,
  output logic                            out_is_power_of_two,
  output logic [1:0]                      out_divisor_class
);
  import npc_pkg::*;

  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [VALUE_WIDTH:0]   t_r, t_nxt;
  logic [TRI_K_WIDTH-1:0] k_r, k_nxt;
  logic [DIV_WIDTH-1:0]   d_r, d_nxt;
  logic [VALUE_WIDTH:0]   sq_r, sq_nxt;
  logic [SUM_WIDTH-1:0]   sum_r, sum_nxt;
  logic                   comp_r, comp_nxt;
  logic                   sqhit_r, sqhit_nxt;

  logic                   nat_r, even_r, prime_r, tri_r, square_r, fact_r, pow2_r;
  logic [1:0]             cls_r;

  logic                   pos;
  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] quo;
  logic [DIV_WIDTH-1:0]   rem;
  logic [VALUE_WIDTH-1:0] d_ext;
  logic [SUM_WIDTH-1:0]   twice_n;
  logic [1:0]             cls;

  npc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (n_r),
    .divisor   (d_r),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  assign pos     = !n_r[VALUE_WIDTH-1] && (n_r != '0);
  assign d_ext   = VALUE_WIDTH'(d_r);
  assign twice_n = {{(SUM_WIDTH-VALUE_WIDTH-1){1'b0}}, n_r, 1'b0};

  assign status.pos      = pos;
  assign status.tri_done = !pos || (t_r >= {1'b0, n_r});
  assign status.sq_over  = sq_r > {1'b0, n_r};
  assign status.div_busy = div_busy;

  always_comb begin
    n_nxt     = n_r;
    t_nxt     = t_r;
    k_nxt     = k_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    sum_nxt   = sum_r;
    comp_nxt  = comp_r;
    sqhit_nxt = sqhit_r;
    if (cmd.load) begin
      n_nxt     = in_value;
      t_nxt     = '0;
      k_nxt     = TRI_K_WIDTH'(1);
      d_nxt     = DIV_WIDTH'(1);
      sq_nxt    = (VALUE_WIDTH + 1)'(1);
      sum_nxt   = '0;
      comp_nxt  = 1'b0;
      sqhit_nxt = 1'b0;
    end
    if (cmd.tri_step) begin
      t_nxt = t_r + (VALUE_WIDTH + 1)'(k_r);
      k_nxt = k_r + 1'b1;
    end
    if (cmd.acc) begin
      if (rem == '0) begin
        if (quo != d_ext) begin
          sum_nxt = sum_r + SUM_WIDTH'(d_r) + SUM_WIDTH'(quo);
        end else begin
          sum_nxt = sum_r + SUM_WIDTH'(d_r);
        end
        if (d_r != DIV_WIDTH'(1)) begin
          comp_nxt = 1'b1;
        end
      end
      if (sq_r == {1'b0, n_r}) begin
        sqhit_nxt = 1'b1;
      end
      // (d+1)^2 = d^2 + 2d + 1
      sq_nxt = sq_r + (VALUE_WIDTH + 1)'({d_r, 1'b1});
      d_nxt  = d_r + 1'b1;
    end
  end

  always_comb begin
    if (!pos) begin
      cls = CLASS_NONE;
    end else if (sum_r == twice_n) begin
      cls = CLASS_PERFECT;
    end else if (sum_r > twice_n) begin
      cls = CLASS_ABUNDANT;
    end else begin
      cls = CLASS_DEFICIENT;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    t_r     <= t_nxt;
    k_r     <= k_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    sum_r   <= sum_nxt;
    comp_r  <= comp_nxt;
    sqhit_r <= sqhit_nxt;
    if (cmd.publish) begin
      nat_r    <= !n_r[VALUE_WIDTH-1];
      even_r   <= !n_r[0];
      prime_r  <= pos && (n_r != VALUE_WIDTH'(1)) && !comp_r;
      tri_r    <= pos && (t_r == {1'b0, n_r});
      square_r <= pos && sqhit_r;
      fact_r   <= pos && is_factorial_fn(n_r);
      pow2_r   <= pos && ((n_r & (n_r - 1'b1)) == '0);
      cls_r    <= cls;
    end
  end

  assign out_is_natural      = nat_r;
  assign out_is_even         = even_r;
  assign out_is_prime        = prime_r;
  assign out_is_triangular   = tri_r;
  assign out_is_square       = square_r;
  assign out_is_factorial    = fact_r;
  assign out_is_power_of_two = pow2_r;
  assign out_divisor_class   = cls_r;

endmodule

// ===== hw/rtl/npc_ctrl.sv =====
// ----------------------------------------------------------------------------
// npc_ctrl: controller of the number property classifier
// Sequences the triangular search and the trial divisor loop, owns handshakes.
// ----------------------------------------------------------------------------
module npc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  npc_pkg::status_t status,
  output npc_pkg::cmd_t    cmd
);
  import npc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TRI  = 6'b000010,
    S_TEST = 6'b000100,
    S_DIV  = 6'b001000,
    S_ACC  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TRI;
        end
      end
      S_TRI: begin
        if (status.tri_done) begin
          state_nxt = S_TEST;
        end else begin
          cmd.tri_step = 1'b1;
        end
      end
      S_TEST: begin
        if (!status.pos || status.sq_over) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_TEST;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/number_property_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// number_property_classifier_unit: property flags and divisor class of a value
// Top level: joins the controller and the datapath of the classifier.
// ----------------------------------------------------------------------------
// Usage. One signed word enters on in_value when in_valid is high and in_stall
// is low. The unit then answers with one result word: seven property flags and
// a two-bit divisor class (deficient, perfect, abundant or not classified).
// The input side stalls while a word is being classified; one word is worked
// on at a time.
// Sequence. The triangular search adds one term per cycle. The trial divisor
// loop then runs d = 1 while d*d <= n; for each divisor the controller tests
// the bound, starts the one-bit-per-cycle divider, waits for it and then
// accumulates. A zero or negative word skips both loops and goes straight to
// the result; the next word is taken once the result has been published.
// Output. The result sits in a register; a new word is accepted while the
// last result still waits for its receiver. If the receiver stalls when the
// next result is ready, the unit holds that result internally until the
// output register frees up. Reset empties the unit and clears out_valid.
// ----------------------------------------------------------------------------
module number_property_classifier_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [npc_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_natural,
  output logic                            out_is_even,
  output logic                            out_is_prime,
  output logic                            out_is_triangular,
  output logic                            out_is_square,
  output logic                            out_is_factorial,
  output logic                            out_is_power_of_two,
  output logic [1:0]                      out_divisor_class
);
  import npc_pkg::*;

  // Command and status words are the only link between the two halves.
  cmd_t    cmd;
  status_t status;

  npc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  npc_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_value            (in_value),
    .out_is_natural      (out_is_natural),
    .out_is_even         (out_is_even),
    .out_is_prime        (out_is_prime),
    .out_is_triangular   (out_is_triangular),
    .out_is_square       (out_is_square),
    .out_is_factorial    (out_is_factorial),
    .out_is_power_of_two (out_is_power_of_two),
    .out_divisor_class   (out_divisor_class)
  );

`ifndef ASSERT_OFF
  // An accepted word keeps the input side closed until it is classified.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again while a word was in flight");

  // A fresh result only appears when the controller has published one.
  a_publish_before_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.publish))
    else $error("result valid without a publish");

  // Negative words are never classified by divisor sum.
  a_negative_unclassified: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_natural |-> out_divisor_class == CLASS_NONE)
    else $error("negative word received a divisor class");

  // A prime has proper divisors summing to one, so it is deficient and never a square.
  a_prime_deficient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_prime |-> out_divisor_class == CLASS_DEFICIENT && !out_is_square)
    else $error("prime word with inconsistent flags");
`endif

endmodule
